// ===== sv/ccks_pkg.sv =====
package ccks_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] state_t;

	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	localparam int ROUNDS = 20;
	localparam int STEPS = 2 * ROUNDS;
	localparam int STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

	localparam int BEATS = 8;
	localparam int BEAT_W = $clog2(BEATS);
	localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BEATS - 1);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_PART_0 = 3'd0,
		REG_KEY_PART_1 = 3'd1,
		REG_KEY_PART_2 = 3'd2,
		REG_KEY_PART_3 = 3'd3,
		REG_NONCE_LOW  = 3'd4,
		REG_NONCE_HIGH = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} core_state_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
	} key_cfg_t;

	typedef struct packed {
		logic   valid;
		state_t data;
	} blk_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic state_t init_state(key_cfg_t cfg, word_t ctr);
		state_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int k = 0; k < 4; k++) begin
			s[4 + 2 * k] = cfg.key[k][31:0];
			s[5 + 2 * k] = cfg.key[k][63:32];
		end
		s[12] = ctr;
		s[13] = cfg.nonce_low[31:0];
		s[14] = cfg.nonce_low[63:32];
		s[15] = cfg.nonce_high;
		return s;
	endfunction

	// One half of a quarter-round: the first half rotates by 16 and 12,
	// the second half by 8 and 7.
	function automatic quad_t qr_half(quad_t q, logic second);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t x;
		word_t y;
		quad_t r;
		a = q.a + q.b;
		x = q.d ^ a;
		d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
		c = q.c + d;
		y = q.b ^ c;
		b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
		r.a = a;
		r.b = b;
		r.c = c;
		r.d = d;
		return r;
	endfunction

endpackage

// ===== sv/chacha20_keystream_block.sv =====
// ChaCha20 keystream generator, IETF layout with a 32-bit block counter.
// Key and nonce are loaded through the write port (cfg_we, cfg_index,
// cfg_data); the user must load them only while the block is idle, which
// the block does not enforce. Key and nonce clear to zero at reset. Each
// input transaction on in_valid/in_ready carries one block counter and
// yields eight output transactions on out_valid/out_ready, 64 keystream bits
// each, beat 0 first, with the eighth beat marked by last_of_block. Counters
// enter a two-entry queue, so up to two more counters are taken while a
// block is being computed or drained. The round unit performs half a
// quarter-round on all four columns or diagonals per cycle, between idle and
// done states that take the counter and hand over the block. The first beat
// appears once the block enters the output buffer; later beats follow one per
// cycle while out_ready is high. The output buffer lets the next block be
// computed while the current one drains, and in_ready drops once the queue is
// full. When the receiver stalls, the current beat holds, the finished block
// waits in the round unit, and the queue fills before in_ready drops. Reset
// is asynchronous and empties the queue and all pending work.
module chacha20_keystream_block
	import ccks_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           block_counter,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           keystream_pair,
	output logic [2:0]            pair_index,
	output logic                  last_of_block
);

	key_cfg_t cfg_q;
	logic     ctr_valid;
	logic     ctr_pop;
	word_t    ctr;
	blk_t     blk;
	logic     blk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_PART_0: cfg_q.key[0] <= cfg_data;
				REG_KEY_PART_1: cfg_q.key[1] <= cfg_data;
				REG_KEY_PART_2: cfg_q.key[2] <= cfg_data;
				REG_KEY_PART_3: cfg_q.key[3] <= cfg_data;
				REG_NONCE_LOW:  cfg_q.nonce_low <= cfg_data;
				REG_NONCE_HIGH: cfg_q.nonce_high <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	ccks_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (block_counter),
		.pop_valid  (ctr_valid),
		.pop        (ctr_pop),
		.pop_data   (ctr)
	);

	ccks_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctr_valid (ctr_valid),
		.ctr       (ctr),
		.ctr_pop   (ctr_pop),
		.blk       (blk),
		.blk_ready (blk_ready)
	);

	ccks_beats u_beats (
		.clk            (clk),
		.arst_n         (arst_n),
		.blk            (blk),
		.blk_ready      (blk_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.keystream_pair (keystream_pair),
		.pair_index     (pair_index),
		.last_of_block  (last_of_block)
	);

endmodule

// ===== sv/ccks_fifo.sv =====
module ccks_fifo
	import ccks_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  word_t push_data,
	output logic  pop_valid,
	input  logic  pop,
	output word_t pop_data
);

	word_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/ccks_core.sv =====
module ccks_core
	import ccks_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  key_cfg_t cfg,
	input  logic     ctr_valid,
	input  word_t    ctr,
	output logic     ctr_pop,
	output blk_t     blk,
	input  logic     blk_ready
);

	core_state_t       state_q;
	core_state_t       state_d;
	logic [STEP_W-1:0] step_q;
	state_t            w_q;
	state_t            w_next;
	state_t            init_w;
	word_t             ctr_q;
	logic              diag;
	logic              second;
	logic [1:0]        off1;
	logic [1:0]        off2;
	logic [1:0]        off3;
	quad_t             q_in [4];
	quad_t             q_out [4];

	// A step is half a quarter-round on all four columns or diagonals.
	assign second = step_q[0];
	assign diag = step_q[1];
	assign off1 = {1'b0, diag};
	assign off2 = {diag, 1'b0};
	assign off3 = {diag, diag};

	always_comb begin
		w_next = w_q;
		for (int i = 0; i < 4; i++) begin
			q_in[i].a = w_q[{2'd0, 2'(i)}];
			q_in[i].b = w_q[{2'd1, 2'(2'(i) + off1)}];
			q_in[i].c = w_q[{2'd2, 2'(2'(i) + off2)}];
			q_in[i].d = w_q[{2'd3, 2'(2'(i) + off3)}];
			q_out[i] = qr_half(q_in[i], second);
			w_next[{2'd0, 2'(i)}] = q_out[i].a;
			w_next[{2'd1, 2'(2'(i) + off1)}] = q_out[i].b;
			w_next[{2'd2, 2'(2'(i) + off2)}] = q_out[i].c;
			w_next[{2'd3, 2'(2'(i) + off3)}] = q_out[i].d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctr_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (blk_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		init_w = init_state(cfg, ctr_q);
		ctr_pop = (state_q == ST_IDLE) && ctr_valid;
		blk.valid = (state_q == ST_DONE);
		for (int i = 0; i < 16; i++) begin
			blk.data[i] = w_q[i] + init_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_pop) begin
			w_q <= init_state(cfg, ctr);
			ctr_q <= ctr;
		end else if (state_q == ST_RUN) begin
			w_q <= w_next;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= LAST_STEP))
		else $error("round step counter out of range");

	a_run_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == LAST_STEP) |=> (state_q == ST_DONE))
		else $error("rounds finished without presenting the block");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_pop |=> (state_q == ST_RUN && step_q == '0))
		else $error("counter taken without starting the rounds");

endmodule

// ===== sv/ccks_beats.sv =====
module ccks_beats
	import ccks_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  blk_t              blk,
	output logic              blk_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       keystream_pair,
	output logic [BEAT_W-1:0] pair_index,
	output logic              last_of_block
);

	state_t            buf_q;
	logic [BEAT_W-1:0] beat_q;
	logic              busy_q;
	logic              take;
	logic              last_take;
	logic              blk_load;

	assign take = busy_q && out_ready;
	assign last_take = take && (beat_q == LAST_BEAT);
	assign blk_ready = !busy_q || last_take;
	assign blk_load = blk.valid && blk_ready;

	assign out_valid = busy_q;
	assign keystream_pair = {buf_q[1], buf_q[0]};
	assign pair_index = beat_q;
	assign last_of_block = (beat_q == LAST_BEAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else begin
			if (blk_load) begin
				busy_q <= 1'b1;
				beat_q <= '0;
			end else if (last_take) begin
				busy_q <= 1'b0;
				beat_q <= '0;
			end else if (take) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_load) begin
			buf_q <= blk.data;
		end else if (take) begin
			buf_q <= state_t'(buf_q >> 64);
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		blk_load |-> (!busy_q || (beat_q == LAST_BEAT && out_ready)))
		else $error("block loaded over beats not yet delivered");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(last_take && !blk_load) |=> !busy_q)
		else $error("output still valid after the final beat");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ccks_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PRINT_CAP = 30;

	typedef struct packed {
		logic [63:0] pair;
		logic [2:0]  idx;
		logic        last;
	} beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [31:0]           block_counter;
	logic                  out_valid;
	logic                  out_ready;
	logic [63:0]           keystream_pair;
	logic [2:0]            pair_index;
	logic                  last_of_block;

	logic [63:0] key_reg [4];
	logic [63:0] nonce_lo_reg;
	logic [31:0] nonce_hi_reg;

	beat_t pending_beats [$];
	beat_t head_beat;

	bit stall_en;
	bit send_gaps_en;
	int stall_left;
	int error_count;
	int beats_checked;
	int counters_sent;
	int configs_loaded;
	int cycle_count;

	chacha20_keystream_block u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.block_counter  (block_counter),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.keystream_pair (keystream_pair),
		.pair_index     (pair_index),
		.last_of_block  (last_of_block)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("chacha20_keystream_block verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void predict_block(input logic [31:0] ctr);
		logic [31:0] init_w [16];
		logic [31:0] w [16];
		int r;
		int q;
		int i;
		int qa;
		int qb;
		int qc;
		int qd;
		beat_t beat;
		init_w[0] = SIGMA_0;
		init_w[1] = SIGMA_1;
		init_w[2] = SIGMA_2;
		init_w[3] = SIGMA_3;
		for (i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = key_reg[i][31:0];
			init_w[5 + 2 * i] = key_reg[i][63:32];
		end
		init_w[12] = ctr;
		init_w[13] = nonce_lo_reg[31:0];
		init_w[14] = nonce_lo_reg[63:32];
		init_w[15] = nonce_hi_reg;
		w = init_w;
		for (r = 0; r < ROUNDS / 2; r++) begin
			for (q = 0; q < 8; q++) begin
				if (q < 4) begin
					qa = q;
					qb = 4 + q;
					qc = 8 + q;
					qd = 12 + q;
				end else begin
					qa = q - 4;
					qb = 4 + (q - 3) % 4;
					qc = 8 + (q - 2) % 4;
					qd = 12 + (q - 1) % 4;
				end
				w[qa] = w[qa] + w[qb];
				w[qd] = rotl32(w[qd] ^ w[qa], 16);
				w[qc] = w[qc] + w[qd];
				w[qb] = rotl32(w[qb] ^ w[qc], 12);
				w[qa] = w[qa] + w[qb];
				w[qd] = rotl32(w[qd] ^ w[qa], 8);
				w[qc] = w[qc] + w[qd];
				w[qb] = rotl32(w[qb] ^ w[qc], 7);
			end
		end
		for (i = 0; i < 16; i++)
			w[i] = w[i] + init_w[i];
		for (i = 0; i < 8; i++) begin
			beat.pair = {w[2 * i + 1], w[2 * i]};
			beat.idx = 3'(i);
			beat.last = (i == 7);
			pending_beats.push_back(beat);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat", keystream_pair, '0);
			end else begin
				head_beat = pending_beats.pop_front();
				if (keystream_pair !== head_beat.pair)
					report_mismatch("keystream_pair", keystream_pair, head_beat.pair);
				if (pair_index !== head_beat.idx)
					report_mismatch("pair_index", 64'(pair_index), 64'(head_beat.idx));
				if (last_of_block !== head_beat.last)
					report_mismatch("last_of_block", 64'(last_of_block), 64'(head_beat.last));
				beats_checked++;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stall_en && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_KEY_PART_0: key_reg[0] = value;
			REG_KEY_PART_1: key_reg[1] = value;
			REG_KEY_PART_2: key_reg[2] = value;
			REG_KEY_PART_3: key_reg[3] = value;
			REG_NONCE_LOW:  nonce_lo_reg = value;
			REG_NONCE_HIGH: nonce_hi_reg = value[31:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_config(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3,
			input logic [63:0] nlo, input logic [63:0] nhi);
		write_reg(REG_KEY_PART_0, k0);
		write_reg(REG_KEY_PART_1, k1);
		write_reg(REG_KEY_PART_2, k2);
		write_reg(REG_KEY_PART_3, k3);
		write_reg(REG_NONCE_LOW, nlo);
		write_reg(REG_NONCE_HIGH, nhi);
		cfg_we <= 1'b0;
		configs_loaded++;
	endtask

	task automatic send_counter(input logic [31:0] ctr);
		int gap;
		gap = 0;
		if (send_gaps_en && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		block_counter <= ctr;
		do @(posedge clk); while (!in_ready);
		predict_block(ctr);
		counters_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_counter(32'h0000_0000);
		send_counter(32'h0000_0001);
		send_counter(32'hffff_ffff);
		drain_results();
	endtask

	// Published test vector; the first beat is also checked against the known
	// keystream so the predictor itself is anchored.
	task automatic test_reference_vector();
		load_config(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
			64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
			64'h4a00_0000_0900_0000, 64'h0);
		send_counter(32'h0000_0001);
		if (pending_beats[pending_beats.size() - 8].pair !== 64'h1559_3bd1_e4e7_f110)
			report_mismatch("known first beat", pending_beats[pending_beats.size() - 8].pair,
				64'h1559_3bd1_e4e7_f110);
		send_counter(32'h0000_0000);
		drain_results();
	endtask

	task automatic test_extreme_config();
		load_config('1, '1, '1, '1, '1, '1);
		send_counter(32'h0000_0000);
		send_counter(32'hffff_ffff);
		send_counter(32'h8000_0000);
		send_counter(32'h7fff_ffff);
		send_counter(32'haaaa_aaaa);
		send_counter(32'h5555_5555);
		drain_results();
		load_config('0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, '0, '1, '0);
		send_counter(32'h0000_0000);
		send_counter(32'hffff_ffff);
		drain_results();
	endtask

	// Writes to unused indexes must not disturb the key, and the top half of
	// a nonce_high write must be dropped.
	task automatic test_spare_indexes();
		write_reg(REG_SPARE_6, {$urandom, $urandom});
		write_reg(REG_SPARE_7, {$urandom, $urandom});
		write_reg(REG_NONCE_HIGH, {32'hdead_beef | $urandom, $urandom});
		cfg_we <= 1'b0;
		send_counter($urandom);
		send_counter($urandom);
		drain_results();
	endtask

	task automatic test_random_traffic();
		logic [63:0] vals [6];
		logic [31:0] ctr;
		int phase;
		int n;
		int i;
		for (phase = 0; phase < 6; phase++) begin
			for (i = 0; i < 6; i++) begin
				case ($urandom_range(0, 3))
					0: vals[i] = '0;
					1: vals[i] = '1;
					default: vals[i] = {$urandom, $urandom};
				endcase
			end
			load_config(vals[0], vals[1], vals[2], vals[3], vals[4], vals[5]);
			for (n = 0; n < 50; n++) begin
				if (phase == 5) begin
					stall_en = 1'b0;
					send_gaps_en = 1'b0;
				end else if (n % 10 == 0) begin
					stall_en = ($urandom_range(0, 3) != 0);
					send_gaps_en = ($urandom_range(0, 3) != 0);
				end
				if (phase == 2 && n == 25)
					drain_results();
				case ($urandom_range(0, 7))
					0: ctr = '0;
					1: ctr = '1;
					default: ctr = $urandom;
				endcase
				send_counter(ctr);
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		block_counter = '0;
		key_reg[0] = '0;
		key_reg[1] = '0;
		key_reg[2] = '0;
		key_reg[3] = '0;
		nonce_lo_reg = '0;
		nonce_hi_reg = '0;
		stall_en = 1'b1;
		send_gaps_en = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_reference_vector();
		test_extreme_config();
		test_spare_indexes();
		test_random_traffic();

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d block counters under %0d key and nonce settings.",
			counters_sent, configs_loaded);
		$display("Checked %0d keystream beats; %0d mismatches.", beats_checked, error_count);
		if (error_count == 0) begin
			$display("chacha20_keystream_block verification clean");
		end else begin
			$display("chacha20_keystream_block verification failed");
		end
		$finish;
	end

endmodule
